// ===== rtl/page_replacement_fifo_lru_optimal_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page replacement block
// Shared same-cycle and next-cycle implication check forms.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_OPTIMAL_TOP_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_OPTIMAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PRFLO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PRFLO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prflo_pkg.sv =====
// ----------------------------------------------------------------------------
// prflo_pkg
// Constants, policy codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prflo_pkg;

    // Reference store geometry
    localparam int MAX_REFS = 32;
    localparam int ADDR_W   = $clog2(MAX_REFS);
    localparam int CNT_W    = $clog2(MAX_REFS + 1);
    localparam int PAGE_W   = 8;
    localparam int HITS_W   = 7;
    localparam int MODE_W   = 2;

    // Replacement policy codes (unused code runs as FIFO)
    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPT  = 2'd2;

    // Frame count codes
    localparam logic [1:0] FRAMES_FULL = 2'd3;
    localparam logic [1:0] FRAME_LAST  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic store;       // write the incoming page into the store
        logic run_init;    // clear frames and counters for a new run
        logic apply_look;  // resolve the current reference from the looked-up page
        logic scan_start;  // begin the future-use scan
        logic scan_step;   // advance the future-use scan by one read
        logic apply_opt;   // replace the scan victim with the held page
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;   // optimal miss with all frames full
        logic scan_done;   // victim known
        logic is_last;     // current reference is the final one
    } status_t;

endpackage

// ===== rtl/prflo_datapath.sv =====
// ----------------------------------------------------------------------------
// prflo_datapath
// Reference store, frame registers, policy update, future-use scan, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_replacement_fifo_lru_optimal_top_defines.svh"

module prflo_datapath
    import prflo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAGE_W-1:0] page,
    input  logic              cfg_valid,
    input  logic [MODE_W-1:0] cfg_data,
    input  cmd_t              cmd,
    output status_t           stat,
    output logic [PAGE_W-1:0] slot_a_page,
    output logic              slot_a_valid,
    output logic [PAGE_W-1:0] slot_b_page,
    output logic              slot_b_valid,
    output logic [PAGE_W-1:0] slot_c_page,
    output logic              slot_c_valid,
    output logic              was_hit,
    output logic [HITS_W-1:0] hits_so_far,
    output logic              end_of_run,
    output logic              result_valid
);

    // Reference store memory
    logic [PAGE_W-1:0] store_mem [MAX_REFS];
    logic [PAGE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              store_wr;

    // Control and counter state
    logic [MODE_W-1:0] mode_reg, mode_run_reg, mode_run_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [1:0]        used_reg, used_next;
    logic [1:0]        fifo_ptr_reg, fifo_ptr_next;
    logic [HITS_W-1:0] hits_reg, hits_next;
    logic              result_valid_reg, result_valid_next;
    logic              was_hit_reg, was_hit_next;
    logic              end_reg, end_next;

    // Frames and held page
    logic [PAGE_W-1:0] frame_reg [3];
    logic [PAGE_W-1:0] frame_next [3];
    logic [PAGE_W-1:0] cur_page_reg, cur_page_next;

    // Scan state
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_pos_reg, pend_pos_next;
    logic [2:0]        found_reg, found_next;
    logic [ADDR_W-1:0] pos_reg [3];
    logic [ADDR_W-1:0] pos_next [3];

    // Derived signals
    logic [2:0] hit_vec;
    logic       look_hit;
    logic [1:0] hit_at;
    logic       lru_run;
    logic       scan_issue;
    logic       all_found;
    logic [1:0] victim;
    logic       apply_any;
    logic [CNT_W-1:0] idx_plus;

    assign lru_run    = (mode_run_reg == MODE_LRU);
    assign idx_plus   = CNT_W'(idx_reg) + CNT_W'(1);
    assign scan_issue = (scan_addr_reg < count_reg);
    assign all_found  = &found_reg;
    assign apply_any  = cmd.apply_look | cmd.apply_opt;
    assign store_wr   = cmd.store && (count_reg < CNT_W'(MAX_REFS));
    assign rd_addr    = cmd.scan_step ? scan_addr_reg[ADDR_W-1:0] : idx_reg;

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= page;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Lookup of the current reference among resident frames
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit_vec[k] = (2'(k) < used_reg) && (frame_reg[k] == rd_data_reg);
        end
        look_hit = |hit_vec;
        if (hit_vec[0])
        begin
            hit_at = 2'd0;
        end
        else if (hit_vec[1])
        begin
            hit_at = 2'd1;
        end
        else
        begin
            hit_at = 2'd2;
        end
    end

    // Optimal victim: lowest frame with no future use, else farthest use
    always_comb
    begin
        if (!found_reg[0])
        begin
            victim = 2'd0;
        end
        else if (!found_reg[1])
        begin
            victim = 2'd1;
        end
        else if (!found_reg[2])
        begin
            victim = 2'd2;
        end
        else if (pos_reg[0] > pos_reg[1])
        begin
            victim = (pos_reg[0] > pos_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            victim = (pos_reg[1] > pos_reg[2]) ? 2'd1 : 2'd2;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.need_scan = !look_hit && (used_reg == FRAMES_FULL) && (mode_run_reg == MODE_OPT);
        stat.scan_done = all_found || (!pend_valid_reg && !scan_issue);
        stat.is_last   = (idx_plus == count_reg);
    end

    // Next-state logic
    always_comb
    begin
        mode_run_next     = mode_run_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        used_next         = used_reg;
        fifo_ptr_next     = fifo_ptr_reg;
        hits_next         = hits_reg;
        result_valid_next = 1'b0;
        was_hit_next      = was_hit_reg;
        end_next          = end_reg;
        cur_page_next     = cur_page_reg;
        scan_addr_next    = scan_addr_reg;
        pend_valid_next   = pend_valid_reg;
        pend_pos_next     = pend_pos_reg;
        found_next        = found_reg;
        for (int k = 0; k < 3; k++)
        begin
            frame_next[k] = frame_reg[k];
            pos_next[k]   = pos_reg[k];
        end

        // Loading
        if (store_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        // New run
        if (cmd.run_init)
        begin
            used_next     = 2'd0;
            fifo_ptr_next = 2'd0;
            hits_next     = '0;
            idx_next      = '0;
            mode_run_next = mode_reg;
        end

        // Resolve a reference without a scan
        if (cmd.apply_look)
        begin
            if (look_hit)
            begin
                hits_next = hits_reg + HITS_W'(1);
                if (lru_run)
                begin
                    if (hit_at == 2'd0 && used_reg > 2'd1)
                    begin
                        frame_next[0] = frame_reg[1];
                    end
                    if (hit_at <= 2'd1 && used_reg > 2'd2)
                    begin
                        frame_next[1] = frame_reg[2];
                    end
                    frame_next[used_reg - 2'd1] = rd_data_reg;
                end
            end
            else if (used_reg != FRAMES_FULL)
            begin
                frame_next[used_reg] = rd_data_reg;
                used_next = used_reg + 2'd1;
            end
            else if (lru_run)
            begin
                frame_next[0] = frame_reg[1];
                frame_next[1] = frame_reg[2];
                frame_next[2] = rd_data_reg;
            end
            else
            begin
                frame_next[fifo_ptr_reg] = rd_data_reg;
                fifo_ptr_next = (fifo_ptr_reg == FRAME_LAST) ? 2'd0 : fifo_ptr_reg + 2'd1;
            end
        end

        // Scan setup: hold the page, search from the next reference
        if (cmd.scan_start)
        begin
            cur_page_next   = rd_data_reg;
            scan_addr_next  = idx_plus;
            pend_valid_next = 1'b0;
            found_next      = 3'b000;
        end

        // Scan: issue one read, compare the previous one
        if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                scan_addr_next = scan_addr_reg + CNT_W'(1);
            end
            pend_valid_next = scan_issue;
            pend_pos_next   = scan_addr_reg[ADDR_W-1:0];
            if (pend_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!found_reg[k] && rd_data_reg == frame_reg[k])
                    begin
                        found_next[k] = 1'b1;
                        pos_next[k]   = pend_pos_reg;
                    end
                end
            end
        end

        // Optimal replacement
        if (cmd.apply_opt)
        begin
            frame_next[victim] = cur_page_reg;
        end

        // Result and advance
        if (apply_any)
        begin
            result_valid_next = 1'b1;
            was_hit_next      = cmd.apply_look && look_hit;
            end_next          = stat.is_last;
            if (stat.is_last)
            begin
                idx_next   = '0;
                count_next = '0;
            end
            else
            begin
                idx_next = idx_plus[ADDR_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_FIFO;
            mode_run_reg     <= MODE_FIFO;
            count_reg        <= '0;
            idx_reg          <= '0;
            used_reg         <= 2'd0;
            fifo_ptr_reg     <= 2'd0;
            hits_reg         <= '0;
            result_valid_reg <= 1'b0;
            scan_addr_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            found_reg        <= 3'b000;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            mode_run_reg     <= mode_run_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            used_reg         <= used_next;
            fifo_ptr_reg     <= fifo_ptr_next;
            hits_reg         <= hits_next;
            result_valid_reg <= result_valid_next;
            scan_addr_reg    <= scan_addr_next;
            pend_valid_reg   <= pend_valid_next;
            found_reg        <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        was_hit_reg  <= was_hit_next;
        end_reg      <= end_next;
        cur_page_reg <= cur_page_next;
        pend_pos_reg <= pend_pos_next;
        for (int k = 0; k < 3; k++)
        begin
            frame_reg[k] <= frame_next[k];
            pos_reg[k]   <= pos_next[k];
        end
    end

    // Display mapping: LRU shows the recency list reversed
    always_comb
    begin
        slot_a_valid = lru_run ? (used_reg > 2'd2) : (used_reg > 2'd0);
        slot_b_valid = used_reg > 2'd1;
        slot_c_valid = lru_run ? (used_reg > 2'd0) : (used_reg > 2'd2);
        slot_a_page  = slot_a_valid ? (lru_run ? frame_reg[2] : frame_reg[0]) : '0;
        slot_b_page  = slot_b_valid ? frame_reg[1] : '0;
        slot_c_page  = slot_c_valid ? (lru_run ? frame_reg[0] : frame_reg[2]) : '0;
    end

    assign was_hit      = was_hit_reg;
    assign hits_so_far  = hits_reg;
    assign end_of_run   = end_reg;
    assign result_valid = result_valid_reg;

    // Checks
    `PRFLO_ASSERT_NEXT(a_strobe_single, result_valid_reg, !result_valid_reg,
        "result strobes in consecutive cycles")
    `PRFLO_ASSERT_NOW(a_end_clears, result_valid_reg && end_reg,
        count_reg == '0 && idx_reg == '0, "store not emptied after final result")

endmodule

// ===== rtl/prflo_ctrl.sv =====
// ----------------------------------------------------------------------------
// prflo_ctrl
// Sequencer for loading, per-reference lookup and the optimal-mode scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_replacement_fifo_lru_optimal_top_defines.svh"

module prflo_ctrl
    import prflo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_ref,
    input  status_t stat,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOOK,
        S_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.store = 1'b1;
                    if (last_ref)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (stat.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.apply_look = 1'b1;
                    state_next     = stat.is_last ? S_IDLE : S_READ;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.apply_opt = 1'b1;
                    state_next    = stat.is_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

    // Checks
    `PRFLO_ASSERT_NOW(a_busy_tracks_state, 1'b1,
        busy_reg == (state_reg != S_IDLE), "busy out of step with sequencer")
    `PRFLO_ASSERT_NEXT(a_run_starts, state_reg == S_IDLE && start && last_ref,
        state_reg == S_READ, "run did not start on final item")

endmodule

// ===== rtl/page_replacement_fifo_lru_optimal_top.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_optimal_top
// Three-frame page replacement simulator: FIFO, LRU and optimal policies.
// ----------------------------------------------------------------------------
// Pages are loaded one item per cycle while busy is low (up to 32 stored;
// more are dropped). The item with last_ref set starts a run: busy rises and
// one result per stored reference is strobed on result_valid for a single
// cycle, in order; the receiver cannot stall, so it must take each result as
// it appears. A reference takes a store read, then a lookup and update;
// in optimal mode a miss with all frames full adds a scan of the remaining
// references, one store read per reference, stopping early once all three
// frames have a next use; the reference store has a single read port.
// The final result strobes in the first cycle with busy low. policy_mode is
// written through cfg_valid/cfg_data (always ready) and is sampled at run start.
`timescale 1ns / 1ps

module page_replacement_fifo_lru_optimal_top
    import prflo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PAGE_W-1:0] page,
    input  logic              last_ref,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data,
    output logic              result_valid,
    output logic [PAGE_W-1:0] slot_a_page,
    output logic              slot_a_valid,
    output logic [PAGE_W-1:0] slot_b_page,
    output logic              slot_b_valid,
    output logic [PAGE_W-1:0] slot_c_page,
    output logic              slot_c_valid,
    output logic              was_hit,
    output logic [HITS_W-1:0] hits_so_far,
    output logic              end_of_run
);

    cmd_t    cmd;
    status_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    prflo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_ref (last_ref),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Store, frames and result registers
    prflo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .page         (page),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .slot_a_page  (slot_a_page),
        .slot_a_valid (slot_a_valid),
        .slot_b_page  (slot_b_page),
        .slot_b_valid (slot_b_valid),
        .slot_c_page  (slot_c_page),
        .slot_c_valid (slot_c_valid),
        .was_hit      (was_hit),
        .hits_so_far  (hits_so_far),
        .end_of_run   (end_of_run),
        .result_valid (result_valid)
    );

endmodule
